// ----- sv/coulomb_pair_force_top_defines.svh -----
// Assertion macros shared by the pair force checker.
`ifndef COULOMB_PAIR_FORCE_TOP_DEFINES_SVH
`define COULOMB_PAIR_FORCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CPF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CPF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/cpf_pkg.sv -----
// Shared types and constants of the pairwise Coulomb force block.
package cpf_pkg;

   localparam int K_WIDTH        = 32;
   localparam int FRAC_BITS      = 16;
   localparam int FORCE_WIDTH    = 32;
   localparam int QUO_BITS       = FORCE_WIDTH - 1;
   localparam int MUL_LIMB       = 32;
   localparam int ADDR_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_IDX_WIDTH  = ADDR_WIDTH - 2;

   localparam logic [REG_IDX_WIDTH-1:0] REG_COUPLING   = '0;
   localparam logic [K_WIDTH-1:0]       COUPLING_RESET = 32'h0001_0000;
   localparam logic [QUO_BITS-1:0]      FORCE_MAX      = '1;

   // Per-request control bits that travel down the cell rows
   typedef struct packed {
      logic valid;
      logic coinc;
      logic neg_x;
      logic neg_y;
      logic sat_x;
      logic sat_y;
   } cpf_flags_type;

   typedef struct packed {
      logic signed [FORCE_WIDTH-1:0] force_x;
      logic signed [FORCE_WIDTH-1:0] force_y;
      logic                          coincident;
      logic                          saturated;
   } cpf_result_type;

endpackage

// ----- sv/cpf_if.sv -----
// Request and response channel interfaces of the pair force block.
interface cpf_req_if #(
   parameter int POS_WIDTH    = 32,
   parameter int CHARGE_WIDTH = 16
) ();
   logic                           valid;
   logic                           ready;
   logic signed [POS_WIDTH-1:0]    first_x;
   logic signed [POS_WIDTH-1:0]    first_y;
   logic signed [POS_WIDTH-1:0]    second_x;
   logic signed [POS_WIDTH-1:0]    second_y;
   logic signed [CHARGE_WIDTH-1:0] first_charge;
   logic signed [CHARGE_WIDTH-1:0] second_charge;

   modport source (output valid, first_x, first_y, second_x, second_y,
                   first_charge, second_charge, input ready);
   modport sink (input valid, first_x, first_y, second_x, second_y,
                 first_charge, second_charge, output ready);
endinterface

interface cpf_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic               coincident;
   logic               saturated;

   modport source (output valid, force_x, force_y, coincident, saturated, input ready);
   modport sink (input valid, force_x, force_y, coincident, saturated, output ready);
endinterface

// ----- sv/coulomb_pair_force_top.sv -----
// Pairwise 2-D Coulomb force: top level with front multipliers, cell rows and output skid.
// Takes one particle pair per request and returns the force on the first particle in
// signed Q16.16, saturated to +/-(2^31-1) so the partner's force is the exact negation.
// A new request is taken every cycle while the skid register is free; a response is
// computed by the row of POS_WIDTH+1 square root cells and the row of 31 divider
// cells, plus the multiplier and edge stages.
// The output register and a skid register let the block take a request while a
// response waits. Coincident positions give zero force with coincident set. Write
// coupling_constant (Q16.16, reset 1.0) over the APB port only while no request is in
// flight. There is no memory and no clearing pass after reset.
module coulomb_pair_force_top #(
   parameter int POS_WIDTH    = 32,
   parameter int CHARGE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cpf_req_if.sink                              req_bus,
   cpf_rsp_if.source                            rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cpf_pkg::ADDR_WIDTH-1:0]       paddr,
   input  logic [cpf_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [cpf_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import cpf_pkg::*;

   localparam int PW      = POS_WIDTH;
   localparam int CW      = CHARGE_WIDTH;
   localparam int SW      = 2 * PW + 1;
   localparam int RW      = PW + 1;
   localparam int DENW    = SW + RW;
   localparam int KAW     = K_WIDTH + CW;
   localparam int BASEW   = K_WIDTH + 2 * CW;
   localparam int NPW     = BASEW + PW;
   localparam int NUMW    = NPW + FRAC_BITS;
   localparam int DIVW    = (NUMW > DENW + QUO_BITS) ? NUMW : DENW + QUO_BITS;
   localparam int NFRONT  = 7;

   typedef struct packed {
      cpf_flags_type    flags;
      logic [PW-1:0]    dx_mag;
      logic [PW-1:0]    dy_mag;
      logic [CW-1:0]    a1;
      logic [CW-1:0]    a2;
      logic [SW-1:0]    s;
   } front_type;

   typedef struct packed {
      cpf_flags_type   flags;
      logic [NUMW-1:0] num_x;
      logic [NUMW-1:0] num_y;
   } tail_type;

   // Configuration register
   logic [K_WIDTH-1:0]       coupling_ff;
   logic [REG_IDX_WIDTH-1:0] reg_index;

   // Pipeline control
   logic en;
   logic pop;

   // Front stages
   logic [PW:0]      dx_s;
   logic [PW:0]      dy_s;
   logic [PW:0]      dx_abs;
   logic [PW:0]      dy_abs;
   logic [CW-1:0]    c1_abs;
   logic [CW-1:0]    c2_abs;
   logic             q_neg;
   front_type        front_in [NFRONT];
   front_type        front_ff [NFRONT];
   logic [2*PW-1:0]  sqx_p;
   logic [2*PW-1:0]  sqy_p;
   logic [KAW-1:0]   ka_p;
   logic [BASEW-1:0] base_p;
   logic [NPW-1:0]   numx_p;
   logic [NPW-1:0]   numy_p;

   // Square root row
   cpf_flags_type   sq_flags [RW+1];
   logic [SW-1:0]   sq_s     [RW+1];
   logic [SW-1:0]   sq_rem   [RW+1];
   logic [RW-1:0]   sq_root  [RW+1];
   logic [NUMW-1:0] sq_nx    [RW+1];
   logic [NUMW-1:0] sq_ny    [RW+1];

   // Divisor and overflow stage
   logic [DENW-1:0] den_p;
   tail_type        tail_in [2];
   tail_type        tail_ff [2];
   logic [DIVW-1:0] den_top;
   cpf_flags_type   head_flags_in;
   cpf_flags_type   head_flags_ff;
   logic [DIVW-1:0] head_rx_ff;
   logic [DIVW-1:0] head_ry_ff;
   logic [DENW-1:0] head_den_ff;

   // Divider row
   cpf_flags_type       dv_flags [QUO_BITS+1];
   logic [DIVW-1:0]     dv_rx    [QUO_BITS+1];
   logic [DIVW-1:0]     dv_ry    [QUO_BITS+1];
   logic [QUO_BITS-1:0] dv_qx    [QUO_BITS+1];
   logic [QUO_BITS-1:0] dv_qy    [QUO_BITS+1];
   logic [DENW-1:0]     dv_den   [QUO_BITS+1];

   // Result and output skid
   logic [QUO_BITS-1:0] mag_x;
   logic [QUO_BITS-1:0] mag_y;
   cpf_result_type      res_in;
   logic                p_valid_ff;
   cpf_result_type      p_res_ff;
   logic                out_valid_ff;
   cpf_result_type      out_res_ff;
   logic                skid_valid_ff;
   cpf_result_type      skid_res_ff;

   // ---------------- configuration port ----------------
   assign reg_index = paddr[ADDR_WIDTH-1:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= COUPLING_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (reg_index)
            REG_COUPLING: coupling_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_COUPLING: prdata = coupling_ff;
         default:      prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   // Advance every stage while the skid register is free
   assign en            = !skid_valid_ff;
   assign req_bus.ready = en;
   assign pop           = out_valid_ff && rsp_bus.ready;

   // ---------------- front: offsets, magnitudes, products ----------------
   assign dx_s   = {req_bus.second_x[PW-1], req_bus.second_x}
                 - {req_bus.first_x[PW-1], req_bus.first_x};
   assign dy_s   = {req_bus.second_y[PW-1], req_bus.second_y}
                 - {req_bus.first_y[PW-1], req_bus.first_y};
   assign dx_abs = dx_s[PW] ? -dx_s : dx_s;
   assign dy_abs = dy_s[PW] ? -dy_s : dy_s;
   assign c1_abs = req_bus.first_charge[CW-1] ? -req_bus.first_charge : req_bus.first_charge;
   assign c2_abs = req_bus.second_charge[CW-1] ? -req_bus.second_charge
                                               : req_bus.second_charge;
   assign q_neg  = req_bus.first_charge[CW-1] ^ req_bus.second_charge[CW-1];

   always_comb begin
      front_in[0].flags.valid = req_bus.valid;
      front_in[0].flags.coinc = (dx_s == '0) && (dy_s == '0);
      // like charges on the same side push the first particle away
      front_in[0].flags.neg_x = ~(q_neg ^ dx_s[PW]);
      front_in[0].flags.neg_y = ~(q_neg ^ dy_s[PW]);
      front_in[0].flags.sat_x = 1'b0;
      front_in[0].flags.sat_y = 1'b0;
      front_in[0].dx_mag      = dx_abs[PW-1:0];
      front_in[0].dy_mag      = dy_abs[PW-1:0];
      front_in[0].a1          = c1_abs;
      front_in[0].a2          = c2_abs;
      front_in[0].s           = '0;
      for (int k = 1; k < NFRONT; k++) begin
         front_in[k] = front_ff[k-1];
      end
      front_in[3].s    = SW'(sqx_p) + SW'(sqy_p);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NFRONT; k++) begin
            front_ff[k].flags.valid <= 1'b0;
         end
      end else if (en) begin
         front_ff <= front_in;
      end
   end

   cpf_mul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_mul_sqx (
      .clock(clock), .en(en), .a(front_ff[0].dx_mag), .b(front_ff[0].dx_mag), .p(sqx_p));

   cpf_mul #(.A_WIDTH(PW), .B_WIDTH(PW)) u_mul_sqy (
      .clock(clock), .en(en), .a(front_ff[0].dy_mag), .b(front_ff[0].dy_mag), .p(sqy_p));

   cpf_mul #(.A_WIDTH(K_WIDTH), .B_WIDTH(CW)) u_mul_ka (
      .clock(clock), .en(en), .a(coupling_ff), .b(front_ff[0].a1), .p(ka_p));

   cpf_mul #(.A_WIDTH(KAW), .B_WIDTH(CW)) u_mul_base (
      .clock(clock), .en(en), .a(ka_p), .b(front_ff[2].a2), .p(base_p));

   // base_p lines up with the request held in the fifth front stage
   cpf_mul #(.A_WIDTH(BASEW), .B_WIDTH(PW)) u_mul_numx (
      .clock(clock), .en(en), .a(base_p), .b(front_ff[4].dx_mag), .p(numx_p));

   cpf_mul #(.A_WIDTH(BASEW), .B_WIDTH(PW)) u_mul_numy (
      .clock(clock), .en(en), .a(base_p), .b(front_ff[4].dy_mag), .p(numy_p));

   // ---------------- square root row ----------------
   assign sq_flags[0] = front_ff[NFRONT-1].flags;
   assign sq_s[0]     = front_ff[NFRONT-1].s;
   assign sq_rem[0]   = front_ff[NFRONT-1].s;
   assign sq_root[0]  = '0;
   assign sq_nx[0]    = {numx_p, {FRAC_BITS{1'b0}}};
   assign sq_ny[0]    = {numy_p, {FRAC_BITS{1'b0}}};

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      cpf_sqrt_cell #(
         .S_WIDTH(SW), .R_WIDTH(RW), .N_WIDTH(NUMW), .BIT(RW - 1 - k)
      ) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_flags(sq_flags[k]), .in_s(sq_s[k]), .in_rem(sq_rem[k]),
         .in_root(sq_root[k]), .in_num_x(sq_nx[k]), .in_num_y(sq_ny[k]),
         .out_flags(sq_flags[k+1]), .out_s(sq_s[k+1]), .out_rem(sq_rem[k+1]),
         .out_root(sq_root[k+1]), .out_num_x(sq_nx[k+1]), .out_num_y(sq_ny[k+1]));
   end

   // ---------------- divisor S * floor(sqrt(S)) ----------------
   cpf_mul #(.A_WIDTH(SW), .B_WIDTH(RW)) u_mul_den (
      .clock(clock), .en(en), .a(sq_s[RW]), .b(sq_root[RW]), .p(den_p));

   always_comb begin
      tail_in[0].flags = sq_flags[RW];
      tail_in[0].num_x = sq_nx[RW];
      tail_in[0].num_y = sq_ny[RW];
      tail_in[1]       = tail_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff[0].flags.valid <= 1'b0;
         tail_ff[1].flags.valid <= 1'b0;
      end else if (en) begin
         tail_ff <= tail_in;
      end
   end

   // Flag quotients that would reach 2^31 before the divider row
   always_comb begin
      den_top             = DIVW'(den_p) << QUO_BITS;
      head_flags_in       = tail_ff[1].flags;
      head_flags_in.sat_x = DIVW'(tail_ff[1].num_x) >= den_top;
      head_flags_in.sat_y = DIVW'(tail_ff[1].num_y) >= den_top;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_flags_ff.valid <= 1'b0;
      end else if (en) begin
         head_flags_ff <= head_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_rx_ff  <= DIVW'(tail_ff[1].num_x);
         head_ry_ff  <= DIVW'(tail_ff[1].num_y);
         head_den_ff <= den_p;
      end
   end

   // ---------------- divider row ----------------
   assign dv_flags[0] = head_flags_ff;
   assign dv_rx[0]    = head_rx_ff;
   assign dv_ry[0]    = head_ry_ff;
   assign dv_qx[0]    = '0;
   assign dv_qy[0]    = '0;
   assign dv_den[0]   = head_den_ff;

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      cpf_div_cell #(
         .D_WIDTH(DIVW), .DEN_WIDTH(DENW), .BIT(QUO_BITS - 1 - k)
      ) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_flags(dv_flags[k]), .in_rem_x(dv_rx[k]), .in_rem_y(dv_ry[k]),
         .in_q_x(dv_qx[k]), .in_q_y(dv_qy[k]), .in_den(dv_den[k]),
         .out_flags(dv_flags[k+1]), .out_rem_x(dv_rx[k+1]), .out_rem_y(dv_ry[k+1]),
         .out_q_x(dv_qx[k+1]), .out_q_y(dv_qy[k+1]), .out_den(dv_den[k+1]));
   end

   // ---------------- sign, clip and coincident override ----------------
   always_comb begin
      mag_x = dv_flags[QUO_BITS].sat_x ? FORCE_MAX : dv_qx[QUO_BITS];
      mag_y = dv_flags[QUO_BITS].sat_y ? FORCE_MAX : dv_qy[QUO_BITS];
      res_in.force_x    = dv_flags[QUO_BITS].neg_x ? -{1'b0, mag_x} : {1'b0, mag_x};
      res_in.force_y    = dv_flags[QUO_BITS].neg_y ? -{1'b0, mag_y} : {1'b0, mag_y};
      res_in.coincident = dv_flags[QUO_BITS].coinc;
      res_in.saturated  = dv_flags[QUO_BITS].sat_x | dv_flags[QUO_BITS].sat_y;
      if (dv_flags[QUO_BITS].coinc) begin
         res_in.force_x   = '0;
         res_in.force_y   = '0;
         res_in.saturated = 1'b0;
      end
   end

   // ---------------- output register and skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= dv_flags[QUO_BITS].valid;
         if (p_valid_ff) begin
            if (!out_valid_ff || pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end else if (pop) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_res_ff <= res_in;
         if (p_valid_ff && (!out_valid_ff || pop)) begin
            out_res_ff <= p_res_ff;
         end
         if (p_valid_ff && out_valid_ff && !pop) begin
            skid_res_ff <= p_res_ff;
         end
      end else if (pop) begin
         out_res_ff <= skid_res_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.force_x    = out_res_ff.force_x;
   assign rsp_bus.force_y    = out_res_ff.force_y;
   assign rsp_bus.coincident = out_res_ff.coincident;
   assign rsp_bus.saturated  = out_res_ff.saturated;

endmodule

// ----- sv/cpf_mul.sv -----
// Two-stage limb multiplier: partial products, then shifted sum.
module cpf_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [A_WIDTH-1:0]         a,
   input  logic [B_WIDTH-1:0]         b,
   output logic [A_WIDTH+B_WIDTH-1:0] p
);
   import cpf_pkg::*;

   localparam int NA = (A_WIDTH + MUL_LIMB - 1) / MUL_LIMB;
   localparam int NB = (B_WIDTH + MUL_LIMB - 1) / MUL_LIMB;
   localparam int NP = NA * NB;
   localparam int AE = NA * MUL_LIMB;
   localparam int BE = NB * MUL_LIMB;
   localparam int EW = AE + BE;
   localparam int PP = 2 * MUL_LIMB;

   logic [AE-1:0]              a_ext;
   logic [BE-1:0]              b_ext;
   logic [PP-1:0]              pp_in [NP];
   logic [PP-1:0]              pp_ff [NP];
   logic [EW-1:0]              sum;
   logic [A_WIDTH+B_WIDTH-1:0] p_in;
   logic [A_WIDTH+B_WIDTH-1:0] p_ff;

   assign a_ext = AE'(a);
   assign b_ext = BE'(b);

   // Form one limb-by-limb product each
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i*NB+j] = PP'(a_ext[i*MUL_LIMB +: MUL_LIMB])
                          * PP'(b_ext[j*MUL_LIMB +: MUL_LIMB]);
         end
      end
   end

   // Align and add the registered partial products
   always_comb begin
      sum = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum = sum + (EW'(pp_ff[i*NB+j]) << ((i + j) * MUL_LIMB));
         end
      end
      p_in = sum[A_WIDTH+B_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ----- sv/cpf_sqrt_cell.sv -----
// One cell of the square root row: decides one root bit.
module cpf_sqrt_cell #(
   parameter int S_WIDTH = 65,
   parameter int R_WIDTH = 33,
   parameter int N_WIDTH = 112,
   parameter int BIT     = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cpf_pkg::cpf_flags_type in_flags,
   input  logic [S_WIDTH-1:0]    in_s,
   input  logic [S_WIDTH-1:0]    in_rem,
   input  logic [R_WIDTH-1:0]    in_root,
   input  logic [N_WIDTH-1:0]    in_num_x,
   input  logic [N_WIDTH-1:0]    in_num_y,
   output cpf_pkg::cpf_flags_type out_flags,
   output logic [S_WIDTH-1:0]    out_s,
   output logic [S_WIDTH-1:0]    out_rem,
   output logic [R_WIDTH-1:0]    out_root,
   output logic [N_WIDTH-1:0]    out_num_x,
   output logic [N_WIDTH-1:0]    out_num_y
);
   import cpf_pkg::*;

   localparam int T_WIDTH = 2 * R_WIDTH;

   logic [T_WIDTH-1:0] trial;
   logic [S_WIDTH-1:0] rem_in;
   logic [R_WIDTH-1:0] root_in;
   cpf_flags_type      flags_ff;
   logic [S_WIDTH-1:0] s_ff;
   logic [S_WIDTH-1:0] rem_ff;
   logic [R_WIDTH-1:0] root_ff;
   logic [N_WIDTH-1:0] num_x_ff;
   logic [N_WIDTH-1:0] num_y_ff;

   // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b); take the bit if it fits
   always_comb begin
      trial   = (T_WIDTH'(in_root) << (BIT + 1)) + (T_WIDTH'(1) << (2 * BIT));
      rem_in  = in_rem;
      root_in = in_root;
      if (T_WIDTH'(in_rem) >= trial) begin
         rem_in  = in_rem - trial[S_WIDTH-1:0];
         root_in = in_root | (R_WIDTH'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.valid <= 1'b0;
      end else if (en) begin
         flags_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= in_s;
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         num_x_ff <= in_num_x;
         num_y_ff <= in_num_y;
      end
   end

   assign out_flags = flags_ff;
   assign out_s     = s_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_num_x = num_x_ff;
   assign out_num_y = num_y_ff;

endmodule

// ----- sv/cpf_div_cell.sv -----
// One cell of the divider row: one quotient bit for both force components.
module cpf_div_cell #(
   parameter int D_WIDTH   = 129,
   parameter int DEN_WIDTH = 98,
   parameter int BIT       = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  cpf_pkg::cpf_flags_type           in_flags,
   input  logic [D_WIDTH-1:0]              in_rem_x,
   input  logic [D_WIDTH-1:0]              in_rem_y,
   input  logic [cpf_pkg::QUO_BITS-1:0]    in_q_x,
   input  logic [cpf_pkg::QUO_BITS-1:0]    in_q_y,
   input  logic [DEN_WIDTH-1:0]            in_den,
   output cpf_pkg::cpf_flags_type           out_flags,
   output logic [D_WIDTH-1:0]              out_rem_x,
   output logic [D_WIDTH-1:0]              out_rem_y,
   output logic [cpf_pkg::QUO_BITS-1:0]    out_q_x,
   output logic [cpf_pkg::QUO_BITS-1:0]    out_q_y,
   output logic [DEN_WIDTH-1:0]            out_den
);
   import cpf_pkg::*;

   logic [D_WIDTH-1:0]   shifted;
   logic [D_WIDTH-1:0]   rem_x_in;
   logic [D_WIDTH-1:0]   rem_y_in;
   logic [QUO_BITS-1:0]  q_x_in;
   logic [QUO_BITS-1:0]  q_y_in;
   cpf_flags_type        flags_ff;
   logic [D_WIDTH-1:0]   rem_x_ff;
   logic [D_WIDTH-1:0]   rem_y_ff;
   logic [QUO_BITS-1:0]  q_x_ff;
   logic [QUO_BITS-1:0]  q_y_ff;
   logic [DEN_WIDTH-1:0] den_ff;

   // Restoring step against the divisor aligned to this bit
   always_comb begin
      shifted  = D_WIDTH'(in_den) << BIT;
      rem_x_in = in_rem_x;
      rem_y_in = in_rem_y;
      q_x_in   = in_q_x;
      q_y_in   = in_q_y;
      if (in_rem_x >= shifted) begin
         rem_x_in = in_rem_x - shifted;
         q_x_in   = in_q_x | (QUO_BITS'(1) << BIT);
      end
      if (in_rem_y >= shifted) begin
         rem_y_in = in_rem_y - shifted;
         q_y_in   = in_q_y | (QUO_BITS'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.valid <= 1'b0;
      end else if (en) begin
         flags_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         den_ff   <= in_den;
      end
   end

   assign out_flags = flags_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_den   = den_ff;

endmodule

// ----- sv/cpf_checker.sv -----
// Port-level checker for the pair force block and its bind to the top level.
`include "coulomb_pair_force_top_defines.svh"

module cpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] force_x,
   input logic [31:0] force_y,
   input logic        coincident,
   input logic        saturated
);
   // Hold a stalled response
   `CPF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(force_x) && $stable(force_y), "stalled response changed")
   // Coincident pairs carry no force and no clip
   `CPF_ASSERT_IMP(a_coinc_zero, clock, reset, rsp_valid && coincident, force_x == 32'h0 && force_y == 32'h0 && !saturated, "coincident response not zero")
   // Clipping is symmetric, so the most negative code never shows
   `CPF_ASSERT_IMP(a_no_min, clock, reset, rsp_valid, force_x != 32'h8000_0000 && force_y != 32'h8000_0000, "force outside symmetric range")
   // A clipped response has a component at full scale
   `CPF_ASSERT_IMP(a_sat_full, clock, reset, rsp_valid && saturated, force_x == 32'h7FFF_FFFF || force_x == 32'h8000_0001 || force_y == 32'h7FFF_FFFF || force_y == 32'h8000_0001, "saturated without full-scale component")

endmodule

bind coulomb_pair_force_top cpf_checker u_cpf_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .force_x(rsp_bus.force_x),
   .force_y(rsp_bus.force_y),
   .coincident(rsp_bus.coincident),
   .saturated(rsp_bus.saturated)
);
